>>> design/double_scale_by_power_of_two_defines.svh
// assertion macros for the binary64 power-of-two scaler
// used by the top level only
`ifndef DOUBLE_SCALE_BY_POWER_OF_TWO_DEFINES_SVH
`define DOUBLE_SCALE_BY_POWER_OF_TWO_DEFINES_SVH

// property that holds whenever not in reset
`define DSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property checked during reset as well
`define DSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/dsp2_pkg.sv
// shared constants and types for the binary64 power-of-two scaler
// no dependencies
package dsp2_pkg;
    localparam int unsigned DataWidth  = 64;
    localparam int unsigned ScaleWidth = 32;
    localparam int unsigned FracWidth  = 52;
    localparam int unsigned ExpWidth   = 11;
    localparam int unsigned SInWidth   = 96;
    localparam logic [ExpWidth-1:0] ExpMaxRaw = 11'd2047;
    localparam logic signed [13:0] ScaleLimit = 14'sd2099;

    typedef logic [DataWidth-1:0] word_t;
    typedef logic signed [13:0] exp_t;
endpackage

>>> design/dsp2_core.sv
// combinational scaling datapath: unpack, normalise, add exponent, round
// depends on dsp2_pkg
module dsp2_core
    import dsp2_pkg::*;
(
    input  word_t                   value_bits,
    input  logic signed [ScaleWidth-1:0] scale_exponent,
    output word_t                   result_bits
);
    logic                sgn;
    logic [ExpWidth-1:0] ex;
    logic [FracWidth-1:0] frac;
    logic [FracWidth:0]  mant;
    logic [5:0]          lz;
    exp_t                scl;
    exp_t                e;
    exp_t                sh;
    logic [FracWidth:0]  q;
    logic [FracWidth:0]  rem;
    logic [FracWidth+1:0] half;
    logic [FracWidth:0]  mask;
    logic [FracWidth:0]  qr;

    always_comb begin
        sgn  = value_bits[DataWidth-1];
        ex   = value_bits[DataWidth-2:FracWidth];
        frac = value_bits[FracWidth-1:0];
        lz   = '0;
        for (int i = 0; i < FracWidth; i++) begin
            if (frac[i]) begin
                lz = 6'(FracWidth - i);
            end
        end
        if (scale_exponent > 32'(ScaleLimit)) begin
            scl = ScaleLimit;
        end else if (scale_exponent < -32'(ScaleLimit)) begin
            scl = -ScaleLimit;
        end else begin
            scl = 14'(scale_exponent);
        end
        if (ex == '0) begin
            mant = {1'b0, frac} << lz;
            e    = 14'sd1 - exp_t'({8'd0, lz});
        end else begin
            mant = {1'b1, frac};
            e    = exp_t'({3'd0, ex});
        end
        e    = e + scl;
        sh   = 14'sd1 - e;
        mask = '0;
        half = '0;
        q    = '0;
        if (sh <= 14'sd54 && sh >= 14'sd1) begin
            q    = mant >> sh[5:0];
            mask = ~({(FracWidth+1){1'b1}} << sh[5:0]);
            half = (FracWidth+2)'(1) << (sh[5:0] - 6'd1);
        end
        rem = mant & mask;
        qr  = q + (FracWidth+1)'(({1'b0, rem} > half) || ({1'b0, rem} == half && q[0]));
        if (ex == ExpMaxRaw) begin
            result_bits = value_bits | (word_t'(1) << (FracWidth-1));
            if (frac == '0) begin
                result_bits = value_bits;
            end
        end else if (ex == '0 && frac == '0) begin
            result_bits = value_bits;
        end else if (e >= exp_t'({3'd0, ExpMaxRaw})) begin
            result_bits = {sgn, ExpMaxRaw, {FracWidth{1'b0}}};
        end else if (e >= 14'sd1) begin
            result_bits = {sgn, e[ExpWidth-1:0], mant[FracWidth-1:0]};
        end else if (sh > 14'sd54) begin
            result_bits = {sgn, {(DataWidth-1){1'b0}}};
        end else begin
            result_bits = {sgn, 10'd0, qr};
        end
    end
endmodule

>>> design/double_scale_by_power_of_two.sv
// top level of the binary64 power-of-two scaler (ldexp)
// depends on dsp2_pkg, dsp2_core and double_scale_by_power_of_two_defines.svh
//
// usage:
//   s_axis beat carries value_bits and scale_exponent; m_axis beat carries
//   result_bits, value times two to the scale, rounded to nearest even
//   nans come out quiet, zeros and infinities pass, overflow gives infinity
//   an input beat is held in the input register and its result in the output register
//   throughput: one beat per cycle while the receiver takes results, set by the
//   single input and result register pair around the combinational datapath
//   a stalled receiver holds the result; the input register still
//   advances while the result register is empty or being taken
//   reset: synchronous, active low, empties both registers
`include "double_scale_by_power_of_two_defines.svh"
module double_scale_by_power_of_two
    import dsp2_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SInWidth-1:0] s_axis_tdata,  // value_bits[63:0], scale_exponent[95:64]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DataWidth-1:0] m_axis_tdata  // result_bits[63:0]
);
    logic          in_vld_reg;
    logic          in_vld_next;
    logic [SInWidth-1:0] in_dat_reg;
    logic          out_vld_reg;
    logic          out_vld_next;
    word_t         out_dat_reg;
    word_t         res;
    logic          out_adv;
    logic          in_adv;

    dsp2_core u_core (
        .value_bits     (in_dat_reg[DataWidth-1:0]),
        .scale_exponent (in_dat_reg[SInWidth-1:DataWidth]),
        .result_bits    (res)
    );

    assign out_adv       = !out_vld_reg || m_axis_tready;
    assign in_adv        = !in_vld_reg || out_adv;
    assign s_axis_tready = in_adv;
    assign in_vld_next   = s_axis_tvalid ? 1'b1 : (in_vld_reg && !out_adv);
    assign out_vld_next  = out_adv ? in_vld_reg : out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_adv) begin
                in_vld_reg <= in_vld_next;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_axis_tvalid) begin
            in_dat_reg <= s_axis_tdata;
        end
        if (out_adv && in_vld_reg) begin
            out_dat_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_dat_reg;

    `DSP_ASSERT(a_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result lost while stalled")
    `DSP_ASSERT(a_full, aclk, aresetn, (in_vld_reg && out_vld_reg && !m_axis_tready) |-> !s_axis_tready, "accepted beat into full pipe")
    `DSP_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_axis_tvalid, "valid after reset")
endmodule

>>> bench/double_scale_by_power_of_two_test.sv
// testbench for the binary64 power-of-two scaler: random and directed beats checked
// against a bit-exact predictor of the scaled result; depends on dsp2_pkg and the rtl
module double_scale_by_power_of_two_test;
    import dsp2_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SInWidth-1:0]  s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DataWidth-1:0] m_axis_tdata;

    double_scale_by_power_of_two DUT (.*);

    always #10 aclk = ~aclk;

    logic [SInWidth-1:0]  pending_beats[$];
    logic [DataWidth-1:0] expected_results[$];
    int  fail_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  quiet_tail = 1'b0;
    bit  hold_send = 1'b0;
    int  idle_cycles = 0;

    function automatic logic [63:0] scaled_double(logic [63:0] bits, logic signed [31:0] sc);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] frac;
        logic [63:0] mant;
        longint      e;
        longint      s;
        longint      sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        sgn = bits[63];
        ex = bits[62:52];
        frac = bits[51:0];
        if (ex == ExpMaxRaw) return (frac != 0) ? (bits | (64'd1 << 51)) : bits;
        if (ex == 0 && frac == 0) return bits;
        s = sc;
        if (s > 2099) s = 2099;
        if (s < -2099) s = -2099;
        if (ex == 0) begin
            mant = {12'd0, frac};
            e = 1;
            while (mant[52] == 1'b0) begin
                mant = mant << 1;
                e = e - 1;
            end
        end else begin
            mant = {11'd0, 1'b1, frac};
            e = ex;
        end
        e = e + s;
        if (e >= 2047) return {sgn, 11'h7ff, 52'd0};
        if (e >= 1) return {sgn, e[10:0], mant[51:0]};
        sh = 1 - e;
        if (sh > 54) return {sgn, 63'd0};
        q = mant >> sh;
        rem = mant & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        return {sgn, 63'd0} | q;
    endfunction

    function automatic logic [63:0] random_double();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: b[62:52] = 11'd0;
            1: b[62:52] = 11'h7ff;
            2: b[62:52] = 11'($urandom_range(0, 60));
            3: b[62:52] = 11'($urandom_range(1980, 2046));
            4: b[51:0] = (b[0]) ? 52'd0 : {51'd0, 1'b1} << $urandom_range(0, 51);
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] random_scale();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 4400)) - 2200);
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return 32'($signed($urandom_range(0, 2200)) - 1100);
        endcase
    endfunction

    task automatic queue_beat(logic [63:0] v, logic [31:0] sc);
        pending_beats.push_back({sc, v});
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(
                    scaled_double(s_axis_tdata[63:0], s_axis_tdata[95:64]));
                sent_count <= sent_count + 1;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 9);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0 && !hold_send) begin
                    s_axis_tdata <= pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    logic [63:0] exp_bits;
                    exp_bits = expected_results.pop_front();
                    if (exp_bits !== m_axis_tdata) begin
                        $display("%0t: result_bits expected %h actual %h",
                                 $time, exp_bits, m_axis_tdata);
                        fail_count++;
                    end
                end
                checked_count <= checked_count + 1;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [63:0] dirv[12];
        logic [31:0] dirs[6];
        dirv = '{64'h0, 64'h8000000000000000, 64'h7ff0000000000000, 64'hfff0000000000000,
                 64'h7ff0000000000001, 64'hfff4000000000abc, 64'h0000000000000001,
                 64'h800fffffffffffff, 64'h3ff0000000000000, 64'h7fefffffffffffff,
                 64'h0010000000000000, 64'hbff8000000000000};
        dirs = '{32'h0, 32'h7fffffff, 32'h80000000, 32'd1, 32'hffffffff, 32'hfffffbcc};
        foreach (dirv[i]) queue_beat(dirv[i], dirs[i % 6]);
        // rounding ties and carry into the smallest normal
        queue_beat(64'h3ff8000000000000, -32'sd1023);
        queue_beat(64'h3ff8000000000000, -32'sd1075);
        queue_beat(64'h000fffffffffffff, 32'd0);
        queue_beat(64'h3fefffffffffffff, -32'sd1022);
        queue_beat(64'h3ff0000000000000, -32'sd1075);
        queue_beat(64'h3ff0000000000001, -32'sd1075);
        queue_beat(64'h0000000000000001, 32'd2099);
        queue_beat(64'h3ff0000000000000, 32'd1024);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 900; i++) queue_beat(random_double(), random_scale());
        wait (pending_beats.size() == 0 && expected_results.size() == 0 && !s_axis_tvalid);
        @(posedge aclk);
        hold_send <= 1'b1;
        wait (expected_results.size() == 0);
        @(posedge aclk);
        hold_send <= 1'b0;
        for (int i = 0; i < 900; i++) queue_beat(random_double(), random_scale());
        wait (pending_beats.size() < 150);
        quiet_tail <= 1'b1;
        wait (pending_beats.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
        repeat (10) @(posedge aclk);
        $display("sent %0d beats including zeros, infinities, nans, subnormals and extreme scales",
                 sent_count);
        $display("checked %0d result beats, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
